// ===== design/lun_hex_string_parser_macros.svh =====
// Assertion macros shared by the LUN hex string parser modules.
`ifndef LUN_HEX_STRING_PARSER_MACROS_SVH
`define LUN_HEX_STRING_PARSER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LHSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition in one cycle leads to a result in the next.
`define LHSP_ASSERT_NEXT(lbl, cond, res, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (res)) \
        else $error(msg);

`endif

// ===== design/lhsp_pkg.sv =====
// Types, constants and the character classifier of the LUN hex string parser.
package lhsp_pkg;

    localparam int GROUP_COUNT = 4;
    localparam int GROUP_W     = 16;
    localparam int POS_W       = 2;
    localparam int DCNT_W      = 3;
    localparam int LUN_W       = GROUP_COUNT * GROUP_W;

    localparam logic [DCNT_W-1:0] MAX_DIGITS = 3'd4;
    localparam logic [POS_W-1:0]  LAST_POS   = 2'd3;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_F = 8'h66;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    // What one character means to the parser
    typedef enum logic [1:0] {
        KIND_DIGIT = 2'd0,
        KIND_DASH  = 2'd1,
        KIND_END   = 2'd2,
        KIND_BAD   = 2'd3
    } kind_t;

    // Classified word passed from the front end to the back end
    typedef struct packed {
        kind_t      kind;
        logic [3:0] digit;
    } item_t;

    function automatic item_t classify(input logic [7:0] c);
        item_t      it;
        logic [7:0] diff;
        it.kind  = KIND_BAD;
        it.digit = 4'd0;
        diff     = 8'd0;
        if (c == CHAR_NUL) begin
            it.kind = KIND_END;
        end else if (c == CHAR_DASH) begin
            it.kind = KIND_DASH;
        end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            diff     = c - CHAR_ZERO;
            it.kind  = KIND_DIGIT;
            it.digit = diff[3:0];
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
            diff     = c - CHAR_UP_A + HEX_TEN;
            it.kind  = KIND_DIGIT;
            it.digit = diff[3:0];
        end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
            diff     = c - CHAR_LOW_A + HEX_TEN;
            it.kind  = KIND_DIGIT;
            it.digit = diff[3:0];
        end
        return it;
    endfunction

endpackage

// ===== design/lhsp_front.sv =====
// Front end: accepts characters and registers their classification.
module lhsp_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,      // [7:0] character
    output logic              item_valid,
    input  logic              item_ready,
    output lhsp_pkg::item_t   item
);
    import lhsp_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg,  item_next;
    logic  accept;

    // Stage is free when empty or being drained this cycle
    assign s_tready   = !valid_reg || item_ready;
    assign accept     = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (accept) begin
            valid_next = 1'b1;
            item_next  = classify(s_tdata);
        end else if (item_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

endmodule

// ===== design/lhsp_queue.sv =====
// Short shifting queue between the front end and the back end.
`include "lun_hex_string_parser_macros.svh"
module lhsp_queue #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  lhsp_pkg::item_t   in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output lhsp_pkg::item_t   out_item
);
    import lhsp_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    item_t            entry_reg [DEPTH];
    item_t            entry_next[DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] wr_pos;
    logic             push, pop;

    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[0];
    assign in_ready  = (count_reg != FULL) || out_ready;
    assign pop       = out_valid && out_ready;
    assign push      = in_valid && in_ready;
    assign wr_pos    = pop ? (count_reg - ONE) : count_reg;

    // Head always sits in entry 0; pop shifts down, push lands at the tail
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (pop && i < DEPTH - 1) begin
                entry_next[i] = entry_reg[(i < DEPTH - 1) ? i + 1 : i];
            end else begin
                entry_next[i] = entry_reg[i];
            end
        end
        if (push) begin
            entry_next[wr_pos[IDX_W-1:0]] = in_item;
        end
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + ONE;
        end else if (pop && !push) begin
            count_next = count_reg - ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            entry_reg[i] <= entry_next[i];
        end
    end

    `LHSP_ASSERT(a_count_bound, count_reg <= FULL, "queue count above depth")
    `LHSP_ASSERT_NEXT(a_full_hold, (count_reg == FULL) && !out_ready,
                      count_reg == FULL, "full queue lost a word without a pop")

endmodule

// ===== design/lhsp_back.sv =====
// Back end: parse state update and the registered result word.
`include "lun_hex_string_parser_macros.svh"
module lhsp_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  lhsp_pkg::item_t           item,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [lhsp_pkg::LUN_W-1:0] m_tdata,   // [63:0] lun_value
    output logic [0:0]                m_tuser     // [0] malformed
);
    import lhsp_pkg::*;

    logic [GROUP_W-1:0] group_reg [GROUP_COUNT];
    logic [GROUP_W-1:0] group_next[GROUP_COUNT];
    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic [DCNT_W-1:0]  dcnt_reg,  dcnt_next;
    logic               err_reg,   err_next;
    logic               mval_reg,  mval_next;
    logic [LUN_W-1:0]   lun_reg,   lun_next;
    logic               mal_reg,   mal_next;
    logic               consume;
    logic [GROUP_W-1:0] cur_group;

    assign item_ready = !mval_reg || m_tready;
    assign consume    = item_valid && item_ready;
    assign cur_group  = group_reg[pos_reg];
    assign m_tvalid   = mval_reg;
    assign m_tdata    = lun_reg;
    assign m_tuser    = mal_reg;

    // Per-character parse step
    always_comb begin
        for (int g = 0; g < GROUP_COUNT; g++) begin
            group_next[g] = group_reg[g];
        end
        pos_next  = pos_reg;
        dcnt_next = dcnt_reg;
        err_next  = err_reg;
        lun_next  = lun_reg;
        mal_next  = mal_reg;
        mval_next = mval_reg && !m_tready;
        if (consume) begin
            if (item.kind == KIND_END) begin
                mval_next = 1'b1;
                mal_next  = err_reg;
                lun_next  = err_reg ? '0
                          : {group_reg[0], group_reg[1], group_reg[2], group_reg[3]};
                for (int g = 0; g < GROUP_COUNT; g++) begin
                    group_next[g] = '0;
                end
                pos_next  = '0;
                dcnt_next = '0;
                err_next  = 1'b0;
            end else if (!err_reg) begin
                unique case (item.kind)
                    KIND_DASH: begin
                        if (dcnt_reg == '0 || pos_reg == LAST_POS) begin
                            err_next = 1'b1;
                        end else begin
                            pos_next  = pos_reg + POS_W'(1);
                            dcnt_next = '0;
                        end
                    end
                    KIND_DIGIT: begin
                        if (dcnt_reg >= MAX_DIGITS) begin
                            err_next = 1'b1;
                        end else begin
                            dcnt_next           = dcnt_reg + DCNT_W'(1);
                            group_next[pos_reg] = {cur_group[GROUP_W-5:0], item.digit};
                        end
                    end
                    default: begin
                        err_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < GROUP_COUNT; g++) begin
                group_reg[g] <= '0;
            end
            pos_reg  <= '0;
            dcnt_reg <= '0;
            err_reg  <= 1'b0;
            mval_reg <= 1'b0;
        end else begin
            for (int g = 0; g < GROUP_COUNT; g++) begin
                group_reg[g] <= group_next[g];
            end
            pos_reg  <= pos_next;
            dcnt_reg <= dcnt_next;
            err_reg  <= err_next;
            mval_reg <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        lun_reg <= lun_next;
        mal_reg <= mal_next;
    end

    `LHSP_ASSERT(a_bad_is_zero, !(mval_reg && mal_reg) || (lun_reg == '0),
                 "malformed result carries a nonzero LUN")
    `LHSP_ASSERT(a_digit_bound, dcnt_reg <= MAX_DIGITS, "digit count above limit")
    `LHSP_ASSERT_NEXT(a_end_clears, consume && (item.kind == KIND_END),
                      pos_reg == '0 && dcnt_reg == '0 && !err_reg && mval_reg,
                      "end of string did not clear state or post a result")

endmodule

// ===== design/lun_hex_string_parser.sv =====
// Top level of the LUN hex string parser: front end, queue and back end.
// A result word is registered once its NUL character has passed front end and queue.
// Throughput: one character per cycle unless stalled; front end and result register
// hold one word each, the queue QUEUE_DEPTH words; the back end updates per character.
// Reset: aresetn is synchronous, active low; it empties all stages and clears
// the group values, group index, digit count and error flag.
module lun_hex_string_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] character
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [lhsp_pkg::LUN_W-1:0] m_tdata,   // [63:0] lun_value
    output logic [0:0]                 m_tuser    // [0] malformed
);
    import lhsp_pkg::*;

    logic  fr_valid, fr_ready;
    item_t fr_item;
    logic  q_valid,  q_ready;
    item_t q_item;

    lhsp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .item_valid (fr_valid),
        .item_ready (fr_ready),
        .item       (fr_item)
    );

    lhsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    lhsp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
